@@ rtl/core/sct_pkg.sv @@
`default_nettype none

package sct_pkg;

    // Defaults for the top-level parameters.
    localparam int ENTRIES_DEF    = 64;
    localparam int COORD_BITS_DEF = 16;

    // Fixed field widths.
    localparam int VALUE_BITS   = 32;
    localparam int CFG_BITS     = 17;
    localparam int CFG_IDX_BITS = 2;
    localparam int STATUS_BITS  = 3;

    // Depth of the request queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COL_COUNT = 2'd1;

    // Reset value of both size registers.
    localparam logic [CFG_BITS-1:0] SIZE_RESET = 17'h10000;

    typedef enum logic [1:0] {
        ACT_SET   = 2'd0,
        ACT_ERASE = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_COORD = 3'd1,
        ST_PRESENT   = 3'd2,
        ST_ABSENT    = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    // Classification that the front attaches to each queued item.
    typedef struct packed {
        t_action action;
        logic    bad;
    } t_ctl;

endpackage

`default_nettype wire

@@ rtl/core/sct_ram.sv @@
`default_nettype none

module sct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/sct_queue.sv @@
`default_nettype none

module sct_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_data
);

    import sct_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push_ok, pop_ok;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sct_front.sv @@
`default_nettype none

module sct_front #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [sct_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  wire logic [sct_pkg::CFG_BITS-1:0]         i_cfg_data,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic [1:0]                           i_action,
    input  wire logic [COORD_BITS-1:0]                i_row_index,
    input  wire logic [COORD_BITS-1:0]                i_col_index,
    input  wire logic [sct_pkg::VALUE_BITS-1:0]       i_write_value,
    input  wire logic                                 i_q_full,
    output logic                                      o_q_push,
    output sct_pkg::t_ctl                             o_q_ctl,
    output logic      [COORD_BITS-1:0]                o_q_row,
    output logic      [COORD_BITS-1:0]                o_q_col,
    output logic      [sct_pkg::VALUE_BITS-1:0]       o_q_wval
);

    import sct_pkg::*;

    localparam int CMP_W = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;

    logic [CFG_BITS-1:0] r_row_count;
    logic [CFG_BITS-1:0] r_col_count;
    logic                row_bad, col_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= SIZE_RESET;
            r_col_count <= SIZE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_ROW_COUNT) begin
                r_row_count <= i_cfg_data;
            end else if (i_cfg_idx == REG_COL_COUNT) begin
                r_col_count <= i_cfg_data;
            end
        end
    end

    // A coordinate is valid only when strictly below the configured size.
    assign row_bad = (CMP_W'(i_row_index) >= CMP_W'(r_row_count));
    assign col_bad = (CMP_W'(i_col_index) >= CMP_W'(r_col_count));

    assign o_stall        = i_q_full;
    assign o_q_push       = i_valid && !i_q_full;
    assign o_q_ctl.action = t_action'(i_action);
    assign o_q_ctl.bad    = row_bad || col_bad;
    assign o_q_row        = i_row_index;
    assign o_q_col        = i_col_index;
    assign o_q_wval       = i_write_value;

endmodule

`default_nettype wire

@@ rtl/core/sct_back.sv @@
`default_nettype none

module sct_back #(
    parameter int ENTRIES    = 64,
    parameter int COORD_BITS = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_q_valid,
    output logic                                      o_q_pop,
    input  wire sct_pkg::t_ctl                        i_q_ctl,
    input  wire logic [COORD_BITS-1:0]                i_q_row,
    input  wire logic [COORD_BITS-1:0]                i_q_col,
    input  wire logic [sct_pkg::VALUE_BITS-1:0]       i_q_wval,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic      [sct_pkg::STATUS_BITS-1:0]      o_status,
    output logic                                      o_found,
    output logic      [$clog2(ENTRIES)-1:0]           o_slot_index,
    output logic      [sct_pkg::VALUE_BITS-1:0]       o_read_value,
    output logic      [$clog2(ENTRIES+1)-1:0]         o_entry_count
);

    import sct_pkg::*;

    localparam int SLOT_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int DW     = 2 * COORD_BITS + VALUE_BITS;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_LAST = 5'b00100,
        S_MOVE = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_fill, n_fill;
    logic [CNT_W-1:0]      r_scan, n_scan;
    logic                  r_rd_vld, n_rd_vld;
    logic [SLOT_W-1:0]     r_rd_slot, n_rd_slot;
    t_ctl                  r_ctl, n_ctl;
    logic [COORD_BITS-1:0] r_row, n_row;
    logic [COORD_BITS-1:0] r_col, n_col;
    logic [VALUE_BITS-1:0] r_wval, n_wval;
    t_status               r_res_status, n_res_status;
    logic                  r_res_hit, n_res_hit;
    logic [SLOT_W-1:0]     r_res_slot, n_res_slot;
    logic [VALUE_BITS-1:0] r_res_val, n_res_val;
    logic                  r_o_valid, n_o_valid;
    t_status               r_o_status, n_o_status;
    logic                  r_o_found, n_o_found;
    logic [SLOT_W-1:0]     r_o_slot, n_o_slot;
    logic [VALUE_BITS-1:0] r_o_val, n_o_val;
    logic [CNT_W-1:0]      r_o_count, n_o_count;

    logic                  ram_we, ram_re;
    logic [SLOT_W-1:0]     ram_waddr, ram_raddr;
    logic [DW-1:0]         ram_wdata, rd_data;
    logic [COORD_BITS-1:0] rd_row, rd_col;
    logic [VALUE_BITS-1:0] rd_val;
    logic                  match, full, out_free;
    logic [CNT_W-1:0]      fill_m1;

    sct_ram #(
        .WIDTH (DW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    assign rd_row   = rd_data[DW-1 -: COORD_BITS];
    assign rd_col   = rd_data[VALUE_BITS +: COORD_BITS];
    assign rd_val   = rd_data[VALUE_BITS-1:0];
    assign match    = r_rd_vld && (rd_row == r_row) && (rd_col == r_col);
    assign full     = (r_fill == CNT_W'(ENTRIES));
    assign fill_m1  = r_fill - CNT_W'(1);
    assign out_free = !r_o_valid || !i_stall;

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_scan       = r_scan;
        n_rd_vld     = 1'b0;
        n_rd_slot    = r_rd_slot;
        n_ctl        = r_ctl;
        n_row        = r_row;
        n_col        = r_col;
        n_wval       = r_wval;
        n_res_status = r_res_status;
        n_res_hit    = r_res_hit;
        n_res_slot   = r_res_slot;
        n_res_val    = r_res_val;
        n_o_valid    = r_o_valid && i_stall;
        n_o_status   = r_o_status;
        n_o_found    = r_o_found;
        n_o_slot     = r_o_slot;
        n_o_val      = r_o_val;
        n_o_count    = r_o_count;
        o_q_pop      = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = r_fill[SLOT_W-1:0];
        ram_wdata    = {r_row, r_col, r_wval};
        ram_re       = 1'b0;
        ram_raddr    = r_scan[SLOT_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop      = 1'b1;
                    n_ctl        = i_q_ctl;
                    n_row        = i_q_row;
                    n_col        = i_q_col;
                    n_wval       = i_q_wval;
                    n_scan       = '0;
                    n_res_status = ST_BAD_COORD;
                    n_res_hit    = 1'b0;
                    n_res_slot   = '0;
                    n_res_val    = '0;
                    n_state      = i_q_ctl.bad ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                // One read is issued per cycle; its compare happens in the cycle after.
                if (match || (r_scan >= r_fill)) begin
                    n_res_hit    = match;
                    n_res_slot   = match ? r_rd_slot : '0;
                    n_res_val    = '0;
                    n_res_status = ST_OK;
                    n_state      = S_DONE;
                    unique case (r_ctl.action)
                        ACT_SET: begin
                            if (match) begin
                                n_res_status = ST_PRESENT;
                            end else if (full) begin
                                n_res_status = ST_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                n_res_slot = r_fill[SLOT_W-1:0];
                                n_fill     = r_fill + CNT_W'(1);
                            end
                        end
                        ACT_ERASE: begin
                            if (match) begin
                                n_res_val = rd_val;
                                n_state   = S_LAST;
                            end else begin
                                n_res_status = ST_ABSENT;
                            end
                        end
                        default: begin
                            if (match) begin
                                n_res_val = rd_val;
                            end else begin
                                n_res_status = ST_ABSENT;
                            end
                        end
                    endcase
                end else begin
                    ram_re    = 1'b1;
                    n_rd_vld  = 1'b1;
                    n_rd_slot = r_scan[SLOT_W-1:0];
                    n_scan    = r_scan + CNT_W'(1);
                end
            end
            S_LAST: begin
                ram_re    = 1'b1;
                ram_raddr = fill_m1[SLOT_W-1:0];
                n_state   = S_MOVE;
            end
            S_MOVE: begin
                // The last entry fills the hole left by the erased one.
                ram_we    = 1'b1;
                ram_waddr = r_res_slot;
                ram_wdata = rd_data;
                n_fill    = fill_m1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_found  = r_res_hit;
                    n_o_slot   = r_res_slot;
                    n_o_val    = r_res_val;
                    n_o_count  = r_fill;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_rd_vld  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_rd_vld  <= n_rd_vld;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan       <= n_scan;
        r_rd_slot    <= n_rd_slot;
        r_ctl        <= n_ctl;
        r_row        <= n_row;
        r_col        <= n_col;
        r_wval       <= n_wval;
        r_res_status <= n_res_status;
        r_res_hit    <= n_res_hit;
        r_res_slot   <= n_res_slot;
        r_res_val    <= n_res_val;
        r_o_status   <= n_o_status;
        r_o_found    <= n_o_found;
        r_o_slot     <= n_o_slot;
        r_o_val      <= n_o_val;
        r_o_count    <= n_o_count;
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_found       = r_o_found;
    assign o_slot_index  = r_o_slot;
    assign o_read_value  = r_o_val;
    assign o_entry_count = r_o_count;

endmodule

`default_nettype wire

@@ rtl/core/sparse_coordinate_table.sv @@
// Sparse matrix store kept as a list of (row, column, value) entries.
// Input channel (i_valid / o_stall) takes one item per request: an action
// (set, erase or read), a coordinate and a value used by set. The item is
// checked against the row and column counts and queued. Output channel
// (o_valid / i_stall) returns one item per request with status, found flag,
// slot, stored value and the fill count after the request.
// The back end searches the table one entry per cycle through the RAM read
// port, reading slots below the fill count until a match or the end of the
// list; an erase hit then fetches the last entry and moves it into the hole.
// A bad coordinate skips the search. Requests are served one at a time; a
// two-item queue lets the sender run ahead while one is searched.
// Reset empties the table and sets both counts to 65536; the RAM is not
// cleared since only slots below the fill count are ever read.
// A stalled result holds in the output register; the back end finishes the
// next request and then waits until the output register is free.
// Size registers are to be written through i_cfg_we / i_cfg_idx / i_cfg_data
// only while the block is idle; the user keeps to this, not the block.
`default_nettype none

module sparse_coordinate_table #(
    parameter int ENTRIES    = sct_pkg::ENTRIES_DEF,
    parameter int COORD_BITS = sct_pkg::COORD_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [sct_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  wire logic [sct_pkg::CFG_BITS-1:0]         i_cfg_data,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic [1:0]                           i_action,
    input  wire logic [COORD_BITS-1:0]                i_row_index,
    input  wire logic [COORD_BITS-1:0]                i_col_index,
    input  wire logic [sct_pkg::VALUE_BITS-1:0]       i_write_value,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic      [sct_pkg::STATUS_BITS-1:0]      o_status,
    output logic                                      o_found,
    output logic      [$clog2(ENTRIES)-1:0]           o_slot_index,
    output logic      [sct_pkg::VALUE_BITS-1:0]       o_read_value,
    output logic      [$clog2(ENTRIES+1)-1:0]         o_entry_count
);

    import sct_pkg::*;

    localparam int QW = $bits(t_ctl) + 2 * COORD_BITS + VALUE_BITS;

    logic                  q_push, q_full, q_pop, q_valid;
    logic [QW-1:0]         q_wdata, q_rdata;
    t_ctl                  f_ctl, b_ctl;
    logic [COORD_BITS-1:0] f_row, f_col, b_row, b_col;
    logic [VALUE_BITS-1:0] f_wval, b_wval;

    sct_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_row_index   (i_row_index),
        .i_col_index   (i_col_index),
        .i_write_value (i_write_value),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_ctl       (f_ctl),
        .o_q_row       (f_row),
        .o_q_col       (f_col),
        .o_q_wval      (f_wval)
    );

    assign q_wdata = {f_ctl, f_row, f_col, f_wval};

    sct_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    assign {b_ctl, b_row, b_col, b_wval} = q_rdata;

    sct_back #(
        .ENTRIES    (ENTRIES),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .o_q_pop       (q_pop),
        .i_q_ctl       (b_ctl),
        .i_q_row       (b_row),
        .i_q_col       (b_col),
        .i_q_wval      (b_wval),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_slot_index  (o_slot_index),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count)
    );

endmodule

`default_nettype wire
